>>> rtl/rcfps_pkg.sv
// rcfps_pkg: shared types and constants for the rc frame packet sequencer
// used by rcfps_front, rcfps_queue, rcfps_back and the top level
// no dependencies
package rcfps_pkg;

  // item kind carried on the input tuser bit
  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_DONE  = 1'b1
  } item_kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TX_ADDRESS = 3'd0,
    REG_HOP_A      = 3'd1,
    REG_HOP_B      = 3'd2,
    REG_HOP_C      = 3'd3
  } cfg_reg_e;

  localparam int unsigned STICK_W    = 18;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 56;
  localparam int unsigned IN_TDATA_W = 56;
  localparam int unsigned OUT_TDATA_W = 96;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // classified item handed from front to back
  typedef struct packed {
    item_kind_e                  kind;
    logic [2:0][WORD_W-1:0]      words;
  } entry_t;

  // configuration write bundle
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  // register reset values
  localparam logic [39:0] TX_ADDRESS_RST = 40'd372695620291;
  localparam logic [55:0] HOP_A_RST      = 56'd15258147055874352;
  localparam logic [55:0] HOP_B_RST      = 56'd17236198656915511;
  localparam logic [47:0] HOP_C_RST      = 48'd73951841632062;

  // stick conversion: ch*500000/32767 = 15*ch + ch*8495/32767
  localparam logic [3:0]  INT_MULT     = 4'd15;
  localparam logic [13:0] FRAC_MULT    = 14'd8495;
  localparam logic [31:0] STICK_DIV    = 32'd32767;
  localparam logic [22:0] PULSE_CENTER = 23'd1500000;
  // pulse/750 as (pulse * RECIP_750) >> 32, exact for pulse below 2^22
  localparam logic [22:0] RECIP_750    = 23'd5726624;

  // failsafe words for 1200, 1500 and 2000 us
  localparam logic [15:0] FS_WORD_ONE   = 16'hf9bf;
  localparam logic [15:0] FS_WORD_TWO   = 16'hf82f;
  localparam logic [15:0] FS_WORD_THREE = 16'hf595;

  // packet marker bytes
  localparam logic [7:0] MARK_STICK    = 8'h55;
  localparam logic [7:0] MARK_FS       = 8'haa;
  localparam logic [7:0] MARK_FS_TAIL  = 8'h5a;
  localparam logic [7:0] BIND_HDR_ZERO = 8'hff;
  localparam logic [7:0] BIND_HDR_ONE  = 8'haa;
  localparam logic [7:0] BIND_HDR_TWO  = 8'h55;
  localparam logic [6:0] BIND_RF       = 7'd81;

  // output tdata bit positions
  localparam int unsigned OUT_LOWP_BIT = 7;
  localparam int unsigned OUT_BIND_BIT = 8;

endpackage

>>> rtl/rcfps_front.sv
// rcfps_front: accepts input items and turns stick channels into stick words
// six-stage pipeline, stalls as a whole when the queue is full and the last stage holds an item
// depends on rcfps_pkg
module rcfps_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       in_kind_i,
  input  logic [2:0][rcfps_pkg::STICK_W-1:0]         in_stick_i,
  output logic                                       push_o,
  output rcfps_pkg::entry_t                          push_data_o,
  input  logic                                       full_i
);
  import rcfps_pkg::*;

  logic        adv;
  logic [6:1]  vld_q;
  logic [6:1]  kind_q, kind_d;

  logic [4:1][2:0]         neg_q, neg_d;
  logic [4:1][2:0][17:0]   mag_q, mag_d;
  logic [3:2][2:0][30:0]   r_q, r_d;
  logic [2:0][16:0]        qe3_q, qe3_d;
  logic [2:0][15:0]        q4_q, q4_d;
  logic [2:0][21:0]        pulse5_q, pulse5_d;
  logic [2:0][44:0]        prod6_q, prod6_d;

  logic [31:0] r_full;
  logic [31:0] qe_sum;
  logic [31:0] rem;
  logic [21:0] m15;
  logic [21:0] q1;
  logic [22:0] up, dn;

  // stall everything only when the last stage cannot hand off
  assign adv        = !(vld_q[6] && full_i);
  assign in_ready_o = adv;
  assign push_o     = vld_q[6] && !full_i;

  always_comb begin
    kind_d = {kind_q[5:1], in_kind_i};
    neg_d  = {neg_q[3:1], 3'b000};
    mag_d  = {mag_q[3:1], 54'd0};
    r_d    = {r_q[2], 93'd0};
    for (int l = 0; l < 3; l++) begin
      // stage 1: sign and magnitude
      neg_d[1][l] = in_stick_i[l][17];
      mag_d[1][l] = in_stick_i[l][17] ? (~in_stick_i[l] + 18'd1) : in_stick_i[l];
      // stage 2: fractional product
      r_full      = {14'd0, mag_q[1][l]} * {18'd0, FRAC_MULT};
      r_d[2][l]   = r_full[30:0];
      // stage 3: quotient estimate by 2^15-1, at most one short
      qe_sum      = {1'b0, r_q[2][l]} + {16'd0, r_q[2][l][30:15]};
      qe3_d[l]    = qe_sum[31:15];
      // stage 4: one correction step
      rem         = {1'b0, r_q[3][l]} - {qe3_q[l], 15'd0} + {15'd0, qe3_q[l]};
      q4_d[l]     = 16'(qe3_q[l] + {16'd0, (rem >= STICK_DIV)});
      // stage 5: pulse, negatives clamp to zero (upper clamp out of reach)
      m15         = {mag_q[4][l], 4'd0} - {4'd0, mag_q[4][l]};
      q1          = m15 + {6'd0, q4_q[l]};
      up          = PULSE_CENTER + {1'b0, q1};
      dn          = PULSE_CENTER - {1'b0, q1};
      if (neg_q[4][l]) begin
        pulse5_d[l] = dn[22] ? 22'd0 : dn[21:0];
      end else begin
        pulse5_d[l] = up[21:0];
      end
      // stage 6: reciprocal multiply for /750
      prod6_d[l]  = {23'd0, pulse5_q[l]} * {22'd0, RECIP_750};
    end
  end

  always_comb begin
    push_data_o.kind = item_kind_e'(kind_q[6]);
    for (int l = 0; l < 3; l++) begin
      push_data_o.words[l] = 16'hffff - {3'd0, prod6_q[l][44:32]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[5:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q   <= kind_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      r_q      <= r_d;
      qe3_q    <= qe3_d;
      q4_q     <= q4_d;
      pulse5_q <= pulse5_d;
      prod6_q  <= prod6_d;
    end
  end

endmodule

>>> rtl/rcfps_queue.sv
// rcfps_queue: short register queue between front and back
// depends on rcfps_pkg
module rcfps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rcfps_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output rcfps_pkg::entry_t head_o
);
  import rcfps_pkg::*;

  entry_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wptr_q, rptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;

  assign full_o       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

>>> rtl/rcfps_back.sv
// rcfps_back: frame sequencer, configuration registers and output register
// builds stick, failsafe and bind packets; depends on rcfps_pkg
module rcfps_back #(
  parameter int unsigned FAILSAFE_PERIOD = 17,
  parameter int unsigned HOP_COUNT       = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcfps_pkg::cfg_wr_t                  cfg_i,
  input  logic                                head_valid_i,
  input  rcfps_pkg::entry_t                   head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rcfps_pkg::OUT_TDATA_W-1:0]   out_data_o
);
  import rcfps_pkg::*;

  localparam logic [4:0] HopLast = 5'(HOP_COUNT - 1);
  localparam logic [4:0] FsLast  = 5'(FAILSAFE_PERIOD - 1);

  typedef enum logic [1:0] {
    PH_STICK   = 2'd0,
    PH_BIND    = 2'd1,
    PH_PROGBOX = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  phase_e                  phase_q, phase_d, eff_phase;
  logic [1:0]              slot_q, slot_d;
  logic [4:0]              hop_q, hop_d;
  logic [4:0]              fs_q, fs_d;
  logic [2:0][WORD_W-1:0]  words_q, words_d, sw;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q, out_data_d;

  logic [39:0]  tx_address_q;
  logic [55:0]  hop_a_q, hop_b_q;
  logic [47:0]  hop_c_q;
  logic [159:0] hop_all;
  logic [7:0]   hop_byte;
  logic [15:0]  addr_sum;
  logic         out_free;
  logic         emit;
  logic [6:0]   rf;
  logic         lowp, bindad;
  logic [63:0]  pl_low;
  logic [15:0]  pl_high;

  assign hop_all  = {hop_c_q, hop_b_q, hop_a_q};
  assign hop_byte = hop_all[{hop_q, 3'b000} +: 8];
  assign addr_sum = {8'd0, tx_address_q[7:0]} + {8'd0, tx_address_q[15:8]}
                  + {8'd0, tx_address_q[23:16]} + {8'd0, tx_address_q[31:24]}
                  + {8'd0, tx_address_q[39:32]};

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_valid_i && out_free;

  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    hop_d     = hop_q;
    fs_d      = fs_q;
    words_d   = words_q;
    emit      = 1'b0;
    rf        = '0;
    lowp      = 1'b0;
    bindad    = 1'b0;
    pl_low    = '0;
    pl_high   = '0;
    eff_phase = (head_i.kind == KIND_FRAME) ? PH_STICK : phase_q;
    sw        = (head_i.kind == KIND_FRAME) ? head_i.words : words_q;
    if (pop_o) begin
      if (head_i.kind == KIND_FRAME) begin
        words_d = head_i.words;
      end
      case (eff_phase)
        PH_STICK: begin
          emit    = 1'b1;
          rf      = hop_byte[6:0];
          if (fs_q == '0) begin
            pl_low  = {MARK_FS, 8'h00, FS_WORD_THREE, FS_WORD_TWO, FS_WORD_ONE};
            pl_high = {8'h00, MARK_FS_TAIL};
          end else begin
            pl_low  = {MARK_STICK, 8'h00, sw[2], sw[1], sw[0]};
          end
          phase_d = PH_BIND;
        end
        PH_BIND: begin
          emit   = 1'b1;
          rf     = BIND_RF;
          lowp   = 1'b1;
          bindad = 1'b1;
          case (slot_q)
            2'd0: pl_low = {tx_address_q, BIND_HDR_TWO, BIND_HDR_ONE, BIND_HDR_ZERO};
            2'd1: begin
              pl_low  = {hop_a_q[39:0], 8'd0, addr_sum};
              pl_high = hop_a_q[55:40];
            end
            2'd2: begin
              pl_low  = {hop_b_q[39:0], 8'd1, addr_sum};
              pl_high = hop_b_q[55:40];
            end
            default: begin
              pl_low  = {hop_c_q[39:0], 8'd2, addr_sum};
              pl_high = {8'd0, hop_c_q[47:40]};
            end
          endcase
          slot_d  = slot_q + 2'd1;
          phase_d = PH_PROGBOX;
        end
        PH_PROGBOX: begin
          // silent step, moves to the next hop and failsafe count
          hop_d   = (hop_q == HopLast) ? 5'd0 : hop_q + 5'd1;
          fs_d    = (fs_q == FsLast) ? 5'd0 : fs_q + 5'd1;
          phase_d = PH_DONE;
        end
        default: begin
        end
      endcase
    end
    out_valid_d = out_free ? emit : out_valid_q;
    out_data_d  = emit ? {7'd0, pl_high, pl_low, bindad, lowp, rf} : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      slot_q      <= '0;
      hop_q       <= '0;
      fs_q        <= '0;
      words_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      hop_q       <= hop_d;
      fs_q        <= fs_d;
      words_q     <= words_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_address_q <= TX_ADDRESS_RST;
      hop_a_q      <= HOP_A_RST;
      hop_b_q      <= HOP_B_RST;
      hop_c_q      <= HOP_C_RST;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_TX_ADDRESS: tx_address_q <= cfg_i.wdata[39:0];
        REG_HOP_A:      hop_a_q      <= cfg_i.wdata;
        REG_HOP_B:      hop_b_q      <= cfg_i.wdata;
        REG_HOP_C:      hop_c_q      <= cfg_i.wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop_q <= HopLast)
    else $error("hop position out of range");

  a_fs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q <= FsLast)
    else $error("failsafe count out of range");

  a_bind_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.kind == KIND_DONE && phase_q == PH_BIND)
      |=> out_valid_q && out_data_q[OUT_BIND_BIT] && out_data_q[OUT_LOWP_BIT])
    else $error("bind step gave no bind packet");

endmodule

>>> rtl/rc_frame_packet_sequencer_unit.sv
// rc_frame_packet_sequencer_unit: top level of the rc frame packet sequencer
// instantiates rcfps_front, rcfps_queue and rcfps_back; depends on rcfps_pkg

// Transmit frame sequencer for an rc radio link. A frame tick (tuser 0) brings
// three signed stick channels; each becomes a servo pulse in ns and then a
// 16-bit stick word, and the stick packet (or, whenever the failsafe counter
// is zero, the failsafe packet) goes out at once on the current hop channel.
// Transmit-done items (tuser 1) then send one bind packet on channel 81 at low
// power with the bind address flag set, rotating over four bind packets
// (address, then the twenty hop bytes with the address byte sum), and then a
// silent step that advances the hop position modulo HOP_COUNT and the failsafe
// counter modulo FAILSAFE_PERIOD. Further transmit-done items give nothing
// until the next frame tick. The block takes one item per clock while tready
// is high: the front is a six-stage pipeline (sign split, constant multiply,
// estimate and one correction for the divide by 32767, pulse add, reciprocal
// multiply for the divide by 750), then a four-entry queue, then the sequencer,
// which takes one queue entry per cycle, while the output is free or being
// read, into a registered output. The queue and output register let input
// and output stall independently; tready drops only when the queue is full
// and the pipeline head holds an item. Configuration writes take effect on
// the next clock and are meant for idle periods.
module rc_frame_packet_sequencer_unit #(
  parameter int unsigned FAILSAFE_PERIOD = 17,
  parameter int unsigned HOP_COUNT       = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // stick_one [17:0], stick_two [35:18], stick_three [53:36], zero pad
  input  logic [rcfps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind [0]: 0 frame tick, 1 transmit done
  input  logic                                  s_axis_tuser,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // rf_channel [6:0], low_power [7], bind_address_used [8],
  // payload_low [72:9], payload_high [88:73], zero pad
  output logic [rcfps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [rcfps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rcfps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import rcfps_pkg::*;

  logic [2:0][STICK_W-1:0] sticks;
  logic                    push;
  entry_t                  push_data;
  logic                    full;
  logic                    pop;
  logic                    head_valid;
  entry_t                  head;
  cfg_wr_t                 cfg;

  // unpack the three stick fields from tdata
  assign sticks[0] = s_axis_tdata[17:0];
  assign sticks[1] = s_axis_tdata[35:18];
  assign sticks[2] = s_axis_tdata[53:36];

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  // conversion pipeline
  rcfps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_stick_i  (sticks),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // decoupling queue
  rcfps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // packet sequencer and output register
  rcfps_back #(
    .FAILSAFE_PERIOD (FAILSAFE_PERIOD),
    .HOP_COUNT       (HOP_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
